/* hdl/bpld_pkg.sv */
// Shared types, register map and fixed-point constants for the power limit derating block.
`default_nettype none

package bpld_pkg;

  // Widths of the register, input and result fields.
  localparam int unsigned PowerW   = 20;
  localparam int unsigned CurrentW = 17;
  localparam int unsigned LevelW   = 14;
  localparam int unsigned TempW    = 11;

  // Derating bands: 5 percent of charge level, 5 C of temperature.
  localparam int unsigned LevelBand = 500;
  localparam int unsigned TempBand  = 50;

  // Distances inside a band fit these widths (at most band minus one).
  localparam int unsigned LevelDistW = 9;
  localparam int unsigned TempDistW  = 6;

  // Raw product widths ahead of the constant divisions.
  localparam int unsigned LevelProdW = PowerW + LevelDistW;   // power * level distance
  localparam int unsigned TempProdW  = PowerW + TempDistW;    // power * temperature distance
  localparam int unsigned CurNumW    = CurrentW + 5;          // 18 * current

  // Reciprocals for exact floor division.
  // x / 500 is (x >> 2) / 125 and x / 50 is (x >> 1) / 25;
  // 720 / 1000 reduces to 18 / 25.
  localparam int unsigned Div125Shift = 34;
  localparam int unsigned Div125W     = 28;
  localparam logic [Div125W-1:0] Div125Mul = 28'd137438954;
  localparam int unsigned Div25Shift  = 30;
  localparam int unsigned Div25W      = 26;
  localparam logic [Div25W-1:0] Div25Mul = 26'd42949673;

  // APB register map, one 32-bit word per register.
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    REG_MAX_CHG_PWR  = 3'd0,
    REG_MAX_DIS_PWR  = 3'd1,
    REG_MAX_CHG_CUR  = 3'd2,
    REG_MAX_DIS_CUR  = 3'd3,
    REG_LEVEL_MIN    = 3'd4,
    REG_LEVEL_MAX    = 3'd5,
    REG_TEMP_LOW     = 3'd6,
    REG_TEMP_HIGH    = 3'd7
  } reg_idx_e;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [PowerW-1:0]          max_charge_power;
    logic [PowerW-1:0]          max_discharge_power;
    logic [CurrentW-1:0]        max_charge_current;
    logic [CurrentW-1:0]        max_discharge_current;
    logic [LevelW-1:0]          charge_level_min;
    logic [LevelW-1:0]          charge_level_max;
    logic signed [TempW-1:0]    temp_low_bound;
    logic signed [TempW-1:0]    temp_high_bound;
  } cfg_t;

  // First pipeline stage: raw products and region flags.
  typedef struct packed {
    logic [LevelProdW-1:0] lvl_c;
    logic [LevelProdW-1:0] lvl_d;
    logic [TempProdW-1:0]  thr_c;
    logic [TempProdW-1:0]  thr_d;
    logic [CurNumW-1:0]    cur_num_c;
    logic [CurNumW-1:0]    cur_num_d;
    logic                  lvl_c_full;
    logic                  lvl_d_full;
    logic                  thr_full;
    logic                  empty;
  } prod_t;

  // Second pipeline stage: quotients and region flags.
  typedef struct packed {
    logic [PowerW-1:0]   lvl_c;
    logic [PowerW-1:0]   lvl_d;
    logic [PowerW-1:0]   thr_c;
    logic [PowerW-1:0]   thr_d;
    logic [CurrentW-1:0] cur_c;
    logic [CurrentW-1:0] cur_d;
    logic                lvl_c_full;
    logic                lvl_d_full;
    logic                thr_full;
    logic                empty;
  } quot_t;

endpackage

`default_nettype wire

/* hdl/bpld_regs.sv */
// APB configuration registers for the power limit derating block.
`default_nettype none

module bpld_regs (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [bpld_pkg::AddrW-1:0] paddr,
  input  wire logic [bpld_pkg::DataW-1:0] pwdata,
  output logic [bpld_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output bpld_pkg::cfg_t              cfg_o
);
  import bpld_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_MAX_CHG_PWR: cfg_d.max_charge_power      = pwdata[PowerW-1:0];
        REG_MAX_DIS_PWR: cfg_d.max_discharge_power   = pwdata[PowerW-1:0];
        REG_MAX_CHG_CUR: cfg_d.max_charge_current    = pwdata[CurrentW-1:0];
        REG_MAX_DIS_CUR: cfg_d.max_discharge_current = pwdata[CurrentW-1:0];
        REG_LEVEL_MIN:   cfg_d.charge_level_min      = pwdata[LevelW-1:0];
        REG_LEVEL_MAX:   cfg_d.charge_level_max      = pwdata[LevelW-1:0];
        REG_TEMP_LOW:    cfg_d.temp_low_bound        = $signed(pwdata[TempW-1:0]);
        REG_TEMP_HIGH:   cfg_d.temp_high_bound       = $signed(pwdata[TempW-1:0]);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_charge_power      <= '0;
      cfg_q.max_discharge_power   <= '0;
      cfg_q.max_charge_current    <= '0;
      cfg_q.max_discharge_current <= '0;
      cfg_q.charge_level_min      <= LevelW'(1000);
      cfg_q.charge_level_max      <= LevelW'(9000);
      cfg_q.temp_low_bound        <= -TempW'(100);
      cfg_q.temp_high_bound       <= TempW'(450);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back; temperature bounds are sign-extended.
  always_comb begin
    unique case (idx)
      REG_MAX_CHG_PWR: prdata = DataW'(cfg_q.max_charge_power);
      REG_MAX_DIS_PWR: prdata = DataW'(cfg_q.max_discharge_power);
      REG_MAX_CHG_CUR: prdata = DataW'(cfg_q.max_charge_current);
      REG_MAX_DIS_CUR: prdata = DataW'(cfg_q.max_discharge_current);
      REG_LEVEL_MIN:   prdata = DataW'(cfg_q.charge_level_min);
      REG_LEVEL_MAX:   prdata = DataW'(cfg_q.charge_level_max);
      REG_TEMP_LOW:    prdata = DataW'(cfg_q.temp_low_bound);
      REG_TEMP_HIGH:   prdata = DataW'(cfg_q.temp_high_bound);
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hdl/bpld_prod.sv */
// Pipeline stage one: region decisions, distances and raw power products.
`default_nettype none

module bpld_prod (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire bpld_pkg::cfg_t              cfg_i,
  input  wire logic [bpld_pkg::LevelW-1:0] level_i,
  input  wire logic signed [bpld_pkg::TempW-1:0] temp_i,
  output bpld_pkg::prod_t                  prod_o
);
  import bpld_pkg::*;

  prod_t prod_q, prod_d;

  logic signed [LevelW+1:0] lvl_s, lmin_s, lmax_s, dist_lc, dist_ld;
  logic signed [TempW+1:0]  t_s, lo_s, hi_s, dist_t;
  logic c_zero, c_band, d_zero, d_band, t_zero, t_low, t_high;
  logic [LevelDistW-1:0] dlc, dld;
  logic [TempDistW-1:0]  dt;

  // Charge level regions against both limits.
  always_comb begin
    lvl_s   = $signed({2'b00, level_i});
    lmin_s  = $signed({2'b00, cfg_i.charge_level_min});
    lmax_s  = $signed({2'b00, cfg_i.charge_level_max});
    dist_lc = lmax_s - lvl_s;
    dist_ld = lvl_s - lmin_s;
    c_zero  = lvl_s >= lmax_s;
    c_band  = lvl_s > (lmax_s - $signed((LevelW+2)'(LevelBand)));
    d_zero  = lvl_s <= lmin_s;
    d_band  = lvl_s < (lmin_s + $signed((LevelW+2)'(LevelBand)));
    dlc     = (!c_zero && c_band) ? dist_lc[LevelDistW-1:0] : '0;
    dld     = (!d_zero && d_band) ? dist_ld[LevelDistW-1:0] : '0;
  end

  // Temperature regions; the lower band wins when the two overlap.
  always_comb begin
    t_s    = (TempW+2)'(temp_i);
    lo_s   = (TempW+2)'(cfg_i.temp_low_bound);
    hi_s   = (TempW+2)'(cfg_i.temp_high_bound);
    t_zero = (t_s <= lo_s) || (t_s >= hi_s);
    t_low  = t_s < (lo_s + $signed((TempW+2)'(TempBand)));
    t_high = t_s > (hi_s - $signed((TempW+2)'(TempBand)));
    dist_t = t_low ? (t_s - lo_s) : (hi_s - t_s);
    dt     = (!t_zero && (t_low || t_high)) ? dist_t[TempDistW-1:0] : '0;
  end

  // Products and stage flags.
  always_comb begin
    prod_d.lvl_c      = LevelProdW'(cfg_i.max_charge_power) * LevelProdW'(dlc);
    prod_d.lvl_d      = LevelProdW'(cfg_i.max_discharge_power) * LevelProdW'(dld);
    prod_d.thr_c      = TempProdW'(cfg_i.max_charge_power) * TempProdW'(dt);
    prod_d.thr_d      = TempProdW'(cfg_i.max_discharge_power) * TempProdW'(dt);
    prod_d.cur_num_c  = (CurNumW'(cfg_i.max_charge_current) << 4)
                      + (CurNumW'(cfg_i.max_charge_current) << 1);
    prod_d.cur_num_d  = (CurNumW'(cfg_i.max_discharge_current) << 4)
                      + (CurNumW'(cfg_i.max_discharge_current) << 1);
    prod_d.lvl_c_full = !c_zero && !c_band;
    prod_d.lvl_d_full = !d_zero && !d_band;
    prod_d.thr_full   = !t_zero && !t_low && !t_high;
    prod_d.empty      = (level_i == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

/* hdl/bpld_quot.sv */
// Pipeline stage two: constant divisions by reciprocal multiplication.
`default_nettype none

module bpld_quot (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire bpld_pkg::prod_t prod_i,
  output bpld_pkg::quot_t      quot_o
);
  import bpld_pkg::*;

  localparam int unsigned L125W = LevelProdW - 2 + Div125W;
  localparam int unsigned T25W  = TempProdW - 1 + Div25W;
  localparam int unsigned C25W  = CurNumW + Div25W;

  quot_t quot_q, quot_d;
  logic [L125W-1:0] m_lc, m_ld;
  logic [T25W-1:0]  m_tc, m_td;
  logic [C25W-1:0]  m_cc, m_cd;

  // Divide level products by 500, thermal products by 50, currents by 25.
  always_comb begin
    m_lc = L125W'(prod_i.lvl_c[LevelProdW-1:2]) * L125W'(Div125Mul);
    m_ld = L125W'(prod_i.lvl_d[LevelProdW-1:2]) * L125W'(Div125Mul);
    m_tc = T25W'(prod_i.thr_c[TempProdW-1:1]) * T25W'(Div25Mul);
    m_td = T25W'(prod_i.thr_d[TempProdW-1:1]) * T25W'(Div25Mul);
    m_cc = C25W'(prod_i.cur_num_c) * C25W'(Div25Mul);
    m_cd = C25W'(prod_i.cur_num_d) * C25W'(Div25Mul);

    quot_d.lvl_c      = m_lc[Div125Shift +: PowerW];
    quot_d.lvl_d      = m_ld[Div125Shift +: PowerW];
    quot_d.thr_c      = m_tc[Div25Shift +: PowerW];
    quot_d.thr_d      = m_td[Div25Shift +: PowerW];
    quot_d.cur_c      = m_cc[Div25Shift +: CurrentW];
    quot_d.cur_d      = m_cd[Div25Shift +: CurrentW];
    quot_d.lvl_c_full = prod_i.lvl_c_full;
    quot_d.lvl_d_full = prod_i.lvl_d_full;
    quot_d.thr_full   = prod_i.thr_full;
    quot_d.empty      = prod_i.empty;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= quot_d;
    end
  end

  assign quot_o = quot_q;

endmodule

`default_nettype wire

/* hdl/battery_power_limit_derating.sv */
// Top level of the battery power limit derating block.
//
// Input channel: one beat carries a charge level sample (0.01 percent) and a
// cell temperature sample (0.1 C, two's complement). Output channel: one beat
// per input beat with the available charge and discharge power (0.1 kW),
// each the minimum of rated power, current limit, charge level derating and
// thermal derating.
// The datapath is a four-register pipeline: input register, product stage,
// reciprocal-division stage and output register. Throughput is one beat per
// cycle while the receiver does not stall. When the receiver stalls, the
// stages fill behind the output register and in_stall_o rises only once every
// stage holds a beat; nothing is lost. Reset empties the pipeline and loads
// the register defaults (charge level window 10 to 90 percent, temperature
// window -10 C to 45 C, zero power and current ratings). The user must write
// registers over APB only while no beat is in flight; the block itself does
// not enforce it.
`default_nettype none

module battery_power_limit_derating (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bpld_pkg::AddrW-1:0]    paddr,
  input  wire logic [bpld_pkg::DataW-1:0]    pwdata,
  output logic [bpld_pkg::DataW-1:0]         prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [bpld_pkg::LevelW-1:0]   charge_level_i,
  input  wire logic signed [bpld_pkg::TempW-1:0] cell_temp_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [bpld_pkg::PowerW-1:0]        charge_power_avail_o,
  output logic [bpld_pkg::PowerW-1:0]        discharge_power_avail_o
);
  import bpld_pkg::*;

  cfg_t  cfg;
  prod_t prod;
  quot_t quot;

  logic in_valid_q, s1_valid_q, s2_valid_q, out_valid_q;
  logic en_in, en_s1, en_s2, en_out;
  logic [LevelW-1:0]       level_q;
  logic signed [TempW-1:0] temp_q;
  logic [PowerW-1:0] lim_lc, lim_ld, lim_tc, lim_td, cur_c, cur_d;
  logic [PowerW-1:0] res_c, res_d, chg_q, dis_q;

  bpld_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // A stage loads when it is empty or its content moves on.
  assign en_out     = !out_valid_q || !out_stall_i;
  assign en_s2      = !s2_valid_q || en_out;
  assign en_s1      = !s1_valid_q || en_s2;
  assign en_in      = !in_valid_q || en_s1;
  assign in_stall_o = !en_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en_in)  in_valid_q  <= in_valid_i;
      if (en_s1)  s1_valid_q  <= in_valid_q;
      if (en_s2)  s2_valid_q  <= s1_valid_q;
      if (en_out) out_valid_q <= s2_valid_q;
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (en_in) begin
      level_q <= charge_level_i;
      temp_q  <= cell_temp_i;
    end
  end

  bpld_prod u_prod (
    .clk_i   (clk_i),
    .en_i    (en_s1),
    .cfg_i   (cfg),
    .level_i (level_q),
    .temp_i  (temp_q),
    .prod_o  (prod)
  );

  bpld_quot u_quot (
    .clk_i  (clk_i),
    .en_i   (en_s2),
    .prod_i (prod),
    .quot_o (quot)
  );

  // Pick the full rating outside the bands, then take the minimum of four limits.
  always_comb begin
    lim_lc = quot.lvl_c_full ? cfg.max_charge_power    : quot.lvl_c;
    lim_ld = quot.lvl_d_full ? cfg.max_discharge_power : quot.lvl_d;
    lim_tc = quot.thr_full   ? cfg.max_charge_power    : quot.thr_c;
    lim_td = quot.thr_full   ? cfg.max_discharge_power : quot.thr_d;
    cur_c  = quot.empty ? '0 : PowerW'(quot.cur_c);
    cur_d  = PowerW'(quot.cur_d);

    res_c = cfg.max_charge_power;
    if (cur_c < res_c)  res_c = cur_c;
    if (lim_lc < res_c) res_c = lim_lc;
    if (lim_tc < res_c) res_c = lim_tc;

    res_d = cfg.max_discharge_power;
    if (cur_d < res_d)  res_d = cur_d;
    if (lim_ld < res_d) res_d = lim_ld;
    if (lim_td < res_d) res_d = lim_td;
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (en_out) begin
      chg_q <= res_c;
      dis_q <= res_d;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign charge_power_avail_o    = chg_q;
  assign discharge_power_avail_o = dis_q;

  // Results never exceed the rated power.
  a_chg_le_rating: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (charge_power_avail_o <= cfg.max_charge_power))
    else $error("charge power above rating");

  a_dis_le_rating: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (discharge_power_avail_o <= cfg.max_discharge_power))
    else $error("discharge power above rating");

  // Back-pressure reaches the input only when every stage is occupied.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && s2_valid_q && s1_valid_q && in_valid_q))
    else $error("input stalled with a free stage");

  // A stalled output beat stays valid and is not dropped.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled output beat dropped");

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the battery power limit derating block.
`timescale 1ns / 1ps

module tb;
  import bpld_pkg::*;

  // Expected pair of power limits for one sample beat.
  typedef struct packed {
    logic [PowerW-1:0] chg;
    logic [PowerW-1:0] dis;
  } avail_t;

  localparam longint LBand = longint'(LevelBand);
  localparam longint TBand = longint'(TempBand);
  localparam int unsigned RandPhases = 8;
  localparam int unsigned PhaseSamples = 100;
  localparam int unsigned SettleCycles = 8;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [AddrW-1:0]         paddr;
  logic [DataW-1:0]         pwdata;
  logic [DataW-1:0]         prdata;
  logic                     pready;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [LevelW-1:0]        charge_level_i;
  logic signed [TempW-1:0]  cell_temp_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [PowerW-1:0]        charge_power_avail_o;
  logic [PowerW-1:0]        discharge_power_avail_o;

  // Shadow of the register file and the results still owed by the block.
  cfg_t        limits_cfg;
  avail_t      pending_avail_q[$];
  logic        idle_en;
  int unsigned hold_cycles = 0;
  int unsigned n_errors = 0;
  int unsigned n_samples = 0;
  int unsigned n_results = 0;
  int unsigned n_writes = 0;

  battery_power_limit_derating uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

  function automatic longint lesser(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  // Thermal limit: zero at or past a bound, linear ramp inside the 5 C band.
  function automatic longint thermal_cap(longint power, longint t);
    longint lo;
    longint hi;
    lo = longint'($signed(limits_cfg.temp_low_bound));
    hi = longint'($signed(limits_cfg.temp_high_bound));
    if (t <= lo || t >= hi) return 0;
    if (t < lo + TBand) return power * (t - lo) / TBand;
    if (t > hi - TBand) return power * (hi - t) / TBand;
    return power;
  endfunction

  // Available charge and discharge power for one sample under the current limits.
  function automatic avail_t derate_avail(logic [LevelW-1:0] level,
                                          logic signed [TempW-1:0] temp);
    longint lvl, t, pc, pd, lmin, lmax;
    longint cur_c, cur_d, lvl_c, lvl_d;
    avail_t r;
    lvl  = longint'(level);
    t    = longint'(temp);
    pc   = longint'(limits_cfg.max_charge_power);
    pd   = longint'(limits_cfg.max_discharge_power);
    lmin = longint'(limits_cfg.charge_level_min);
    lmax = longint'(limits_cfg.charge_level_max);

    // An empty battery takes no charge current.
    cur_c = (lvl > 0) ? 720 * longint'(limits_cfg.max_charge_current) / 1000 : 0;
    cur_d = 720 * longint'(limits_cfg.max_discharge_current) / 1000;

    if (lvl >= lmax) lvl_c = 0;
    else if (lvl > lmax - LBand) lvl_c = pc * (lmax - lvl) / LBand;
    else lvl_c = pc;

    if (lvl <= lmin) lvl_d = 0;
    else if (lvl < lmin + LBand) lvl_d = pd * (lvl - lmin) / LBand;
    else lvl_d = pd;

    r.chg = PowerW'(lesser(lesser(pc, cur_c), lesser(lvl_c, thermal_cap(pc, t))));
    r.dis = PowerW'(lesser(lesser(pd, cur_d), lesser(lvl_d, thermal_cap(pd, t))));
    return r;
  endfunction

  // Charge level biased toward the edges of the derating bands.
  function automatic logic [LevelW-1:0] pick_level();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = int'(limits_cfg.charge_level_max) + int'($urandom_range(0, 540)) - 520;
      3, 4, 5: v = int'(limits_cfg.charge_level_min) + int'($urandom_range(0, 540)) - 20;
      6:       v = 0;
      7:       v = int'($urandom_range(0, 16383));
      default: v = int'($urandom_range(0, 10000));
    endcase
    if (v < 0) v = 0;
    if (v > 16383) v = 16383;
    return LevelW'(v);
  endfunction

  // Temperature biased toward the thermal bounds.
  function automatic logic signed [TempW-1:0] pick_temp();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = int'($signed(limits_cfg.temp_low_bound)) + int'($urandom_range(0, 70)) - 10;
      3, 4, 5: v = int'($signed(limits_cfg.temp_high_bound)) - int'($urandom_range(0, 70)) + 10;
      6:       v = int'($urandom_range(0, 2047)) - 1024;
      default: v = int'($urandom_range(0, 1400)) - 400;
    endcase
    if (v < -1024) v = -1024;
    if (v > 1023) v = 1023;
    return TempW'(v);
  endfunction

  // Rating register value: small, at the range top, all ones, or random.
  function automatic logic [DataW-1:0] pick_rating(int unsigned top, int unsigned w);
    case ($urandom_range(0, 5))
      0:       return DataW'($urandom_range(0, 3000));
      1:       return DataW'(top);
      2:       return (DataW'(1) << w) - 1;
      3:       return $urandom();
      default: return DataW'($urandom_range(0, top));
    endcase
  endfunction

  // Window register value, now and then replaced by a random 32-bit word.
  function automatic logic [DataW-1:0] with_noise(int v);
    if ($urandom_range(0, 7) == 0) return $urandom();
    return DataW'(v);
  endfunction

  // One register write over APB: setup cycle, then access until pready.
  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    forever begin
      @(negedge clk_i);
      if (pready) break;
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MAX_CHG_PWR: limits_cfg.max_charge_power      = value[PowerW-1:0];
      REG_MAX_DIS_PWR: limits_cfg.max_discharge_power   = value[PowerW-1:0];
      REG_MAX_CHG_CUR: limits_cfg.max_charge_current    = value[CurrentW-1:0];
      REG_MAX_DIS_CUR: limits_cfg.max_discharge_current = value[CurrentW-1:0];
      REG_LEVEL_MIN:   limits_cfg.charge_level_min      = value[LevelW-1:0];
      REG_LEVEL_MAX:   limits_cfg.charge_level_max      = value[LevelW-1:0];
      REG_TEMP_LOW:    limits_cfg.temp_low_bound        = value[TempW-1:0];
      REG_TEMP_HIGH:   limits_cfg.temp_high_bound       = value[TempW-1:0];
      default: ;
    endcase
    n_writes++;
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [DataW-1:0] pc, input logic [DataW-1:0] pd,
                           input logic [DataW-1:0] cc, input logic [DataW-1:0] cd,
                           input logic [DataW-1:0] lmin, input logic [DataW-1:0] lmax,
                           input logic [DataW-1:0] tlo, input logic [DataW-1:0] thi);
    write_reg(REG_MAX_CHG_PWR, pc);
    write_reg(REG_MAX_DIS_PWR, pd);
    write_reg(REG_MAX_CHG_CUR, cc);
    write_reg(REG_MAX_DIS_CUR, cd);
    write_reg(REG_LEVEL_MIN, lmin);
    write_reg(REG_LEVEL_MAX, lmax);
    write_reg(REG_TEMP_LOW, tlo);
    write_reg(REG_TEMP_HIGH, thi);
  endtask

  // Offer one sample beat, with an optional idle burst ahead of it.
  task automatic send_sample(input logic [LevelW-1:0] level,
                             input logic signed [TempW-1:0] temp);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    charge_level_i <= level;
    cell_temp_i    <= temp;
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
    end
    @(posedge clk_i);
    pending_avail_q.push_back(derate_avail(level, temp));
    n_samples++;
  endtask

  // Stop offering and wait for every owed result, then let the pipeline settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_avail_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // After reset all ratings are zero, so every limit is zero.
  task automatic test_reset_defaults();
    send_sample(LevelW'(5000), TempW'(200));
    send_sample(LevelW'(0), TempW'(-1024));
    send_sample(LevelW'(10000), TempW'(1023));
    wait_idle();
  endtask

  // Band edges of charge level and temperature, plus the empty battery.
  task automatic test_band_edges();
    int lv[15] = '{0, 1, 16383, 10000, 1000, 1001, 1499, 1500, 8500, 8501, 8999, 9000,
                   5000, 5000, 5000};
    int tp[15] = '{250, -99, 1023, -1024, 250, 401, -51, -50, 400, 449, 0, -400,
                   1000, -100, 450};
    write_all(DataW'(1000), DataW'(1200), DataW'(2000), DataW'(1500),
              DataW'(1000), DataW'(9000), DataW'(-100), DataW'(450));
    for (int i = 0; i < 15; i++) send_sample(LevelW'(lv[i]), TempW'(tp[i]));
    wait_idle();
  endtask

  // Equal and crossed temperature bounds leave no operating window.
  task automatic test_crossed_bounds();
    write_reg(REG_TEMP_LOW, DataW'(200));
    write_reg(REG_TEMP_HIGH, DataW'(200));
    send_sample(LevelW'(5000), TempW'(200));
    send_sample(LevelW'(5000), TempW'(100));
    wait_idle();
    write_reg(REG_TEMP_LOW, DataW'(300));
    write_reg(REG_TEMP_HIGH, DataW'(100));
    send_sample(LevelW'(5000), TempW'(200));
    wait_idle();
  endtask

  // Registers at the ends of their ranges and at full field width.
  task automatic test_register_extremes();
    write_all(DataW'(1000000), DataW'(1000000), DataW'(100000), DataW'(100000),
              DataW'(0), DataW'(10000), DataW'(-400), DataW'(1000));
    send_sample(LevelW'(0), TempW'(300));
    send_sample(LevelW'(10000), TempW'(-399));
    send_sample(LevelW'(5000), TempW'(999));
    wait_idle();
    write_all(DataW'(20'hFFFFF), DataW'(20'hFFFFF), DataW'(17'h1FFFF), DataW'(17'h1FFFF),
              DataW'(14'h3FFF), DataW'(14'h3FFF), DataW'(-1024), DataW'(1023));
    send_sample(LevelW'(8000), TempW'(0));
    send_sample(LevelW'(16383), TempW'(1022));
    send_sample(LevelW'(1), TempW'(-1023));
    wait_idle();
  endtask

  // Long output hold-off while the sender keeps offering, so the input stalls.
  task automatic test_output_hold();
    write_all(DataW'(900000), DataW'(700000), DataW'(100000), DataW'(90000),
              DataW'(2000), DataW'(8000), DataW'(-200), DataW'(600));
    idle_en = 1'b0;
    hold_cycles <= 40;
    for (int i = 0; i < 30; i++) send_sample(pick_level(), pick_temp());
    wait_idle();
  endtask

  // Fresh random ratings and windows; bounds are crossed now and then.
  task automatic write_random_limits();
    int a, b, tmp;
    write_reg(REG_MAX_CHG_PWR, pick_rating(1000000, PowerW));
    write_reg(REG_MAX_DIS_PWR, pick_rating(1000000, PowerW));
    write_reg(REG_MAX_CHG_CUR, pick_rating(100000, CurrentW));
    write_reg(REG_MAX_DIS_CUR, pick_rating(100000, CurrentW));
    a = int'($urandom_range(0, 10000));
    b = int'($urandom_range(0, 10000));
    if (a > b && $urandom_range(0, 7) != 0) begin
      tmp = a;
      a = b;
      b = tmp;
    end
    write_reg(REG_LEVEL_MIN, with_noise(a));
    write_reg(REG_LEVEL_MAX, with_noise(b));
    a = int'($urandom_range(0, 1400)) - 400;
    b = int'($urandom_range(0, 1400)) - 400;
    if (a > b && $urandom_range(0, 7) != 0) begin
      tmp = a;
      a = b;
      b = tmp;
    end
    write_reg(REG_TEMP_LOW, with_noise(a));
    write_reg(REG_TEMP_HIGH, with_noise(b));
  endtask

  // Random traffic over several register settings; the last phase runs without gaps.
  task automatic test_random_traffic();
    for (int phase = 0; phase < RandPhases; phase++) begin
      write_random_limits();
      idle_en = (phase != RandPhases - 1);
      for (int i = 0; i < PhaseSamples; i++) send_sample(pick_level(), pick_temp());
      wait_idle();
    end
  endtask

  // Receiver: stall in random bursts, or for a long requested hold-off.
  initial begin : result_sink
    int unsigned n;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        n = hold_cycles;
        hold_cycles <= 0;
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(input string field, input longint want, input longint got);
    n_errors++;
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
  endtask

  // Compare each result beat with the oldest expectation.
  always @(negedge clk_i) begin : avail_check
    avail_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_avail_q.size() == 0) begin
        report_mismatch("unexpected beat, charge_power_avail", -1, charge_power_avail_o);
      end else begin
        want = pending_avail_q.pop_front();
        n_results++;
        if (charge_power_avail_o !== want.chg)
          report_mismatch("charge_power_avail", want.chg, charge_power_avail_o);
        if (discharge_power_avail_o !== want.dis)
          report_mismatch("discharge_power_avail", want.dis, discharge_power_avail_o);
      end
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_valid_i     <= 1'b0;
    charge_level_i <= '0;
    cell_temp_i    <= '0;
    idle_en        <= 1'b1;
    limits_cfg = '{max_charge_power: '0, max_discharge_power: '0,
                   max_charge_current: '0, max_discharge_current: '0,
                   charge_level_min: LevelW'(1000), charge_level_max: LevelW'(9000),
                   temp_low_bound: TempW'(-100), temp_high_bound: TempW'(450)};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_band_edges();
    test_crossed_bounds();
    test_register_extremes();
    test_output_hold();
    test_random_traffic();

    if (pending_avail_q.size() != 0) begin
      n_errors++;
      $display("%0t: %0d expected beats never arrived", $time, pending_avail_q.size());
    end
    $display("Sent %0d samples and checked %0d results across %0d register writes,",
             n_samples, n_results, n_writes);
    $display("with band edges, crossed bounds, a long output hold-off and idle bursts.");
    if (n_errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/bpld_pkg.sv
hdl/bpld_regs.sv
hdl/bpld_prod.sv
hdl/bpld_quot.sv
hdl/battery_power_limit_derating.sv
test/tb.sv
